/* src/mtep_pkg.sv */
`default_nettype none

package mtep_pkg;

	// One raw byte of the track chunk body.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_track;
	} in_item_t;

	// One decoded event.
	typedef struct packed {
		logic [1:0]  event_kind;
		logic [31:0] tick;
		logic [7:0]  status_byte;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [23:0] tempo_us;
	} out_item_t;

	// Parser phases.
	typedef enum logic [3:0] {
		PH_DELTA     = 4'd0,
		PH_STATUS    = 4'd1,
		PH_DATA1     = 4'd2,
		PH_DATA2     = 4'd3,
		PH_SKIP1     = 4'd4,
		PH_META_TYPE = 4'd5,
		PH_META_LEN  = 4'd6,
		PH_TEMPO     = 4'd7,
		PH_SYSEX_LEN = 4'd8,
		PH_SKIP      = 4'd9,
		PH_DONE      = 4'd10
	} phase_t;

	// Event kinds.
	localparam logic [1:0] KIND_CHANNEL = 2'd0;
	localparam logic [1:0] KIND_TEMPO   = 2'd1;
	localparam logic [1:0] KIND_EOT     = 2'd2;

	// Status and meta codes.
	localparam logic [7:0] DATA_MASK     = 8'h7F;
	localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
	localparam logic [7:0] ST_NOTE_ON    = 8'h90;
	localparam logic [7:0] ST_POLY_PRESS = 8'hA0;
	localparam logic [7:0] ST_CTRL       = 8'hB0;
	localparam logic [7:0] ST_PROGRAM    = 8'hC0;
	localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
	localparam logic [7:0] ST_PITCH      = 8'hE0;
	localparam logic [7:0] ST_SYSEX      = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
	localparam logic [7:0] ST_META       = 8'hFF;
	localparam logic [7:0] TYPE_MASK     = 8'hF0;
	localparam logic [7:0] META_TEMPO    = 8'h51;
	localparam logic [7:0] META_EOT      = 8'h2F;

	localparam logic [2:0]  VLQ_MAX_BYTES = 3'd4;
	localparam logic [27:0] TEMPO_LEN     = 28'd3;

endpackage

`default_nettype wire

/* src/mtep_parse.sv */
`default_nettype none

module mtep_parse (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  mtep_pkg::in_item_t   item,
	output logic                 res_valid,
	output mtep_pkg::out_item_t  res
);

	mtep_pkg::phase_t phase_q, phase_d;
	logic [31:0] tick_q, tick_d;
	logic [27:0] vlq_value_q, vlq_value_d;
	logic [2:0]  vlq_bytes_q, vlq_bytes_d;
	logic [7:0]  running_q, running_d;
	logic [7:0]  current_q, current_d;
	logic [7:0]  held_q, held_d;
	logic [7:0]  meta_kind_q, meta_kind_d;
	logic [27:0] skip_q, skip_d;
	logic [23:0] tempo_q, tempo_d;

	// Shared length decoder terms.
	logic [7:0]  b;
	logic [27:0] vlq_next;
	logic [2:0]  vlq_cnt_next;
	logic        vlq_done;
	logic [27:0] skip_dec;
	logic [23:0] tempo_next;
	logic [7:0]  b_type;
	logic [7:0]  run_type;
	logic [7:0]  cur_type;

	assign b            = item.data_byte;
	assign vlq_next     = {vlq_value_q[20:0], b[6:0] & mtep_pkg::DATA_MASK[6:0]};
	assign vlq_cnt_next = vlq_bytes_q + 3'd1;
	assign vlq_done     = !b[7] || (vlq_cnt_next >= mtep_pkg::VLQ_MAX_BYTES);
	assign skip_dec     = skip_q - 28'd1;
	assign tempo_next   = {tempo_q[15:0], b};
	assign b_type       = b & mtep_pkg::TYPE_MASK;
	assign run_type     = running_q & mtep_pkg::TYPE_MASK;
	assign cur_type     = current_q & mtep_pkg::TYPE_MASK;

	function automatic logic two_data(input logic [7:0] t);
		two_data = (t == mtep_pkg::ST_NOTE_OFF) || (t == mtep_pkg::ST_NOTE_ON) ||
			(t == mtep_pkg::ST_CTRL) || (t == mtep_pkg::ST_POLY_PRESS) ||
			(t == mtep_pkg::ST_PITCH);
	endfunction

	// Next state and result for the byte in the input register.
	always_comb begin
		phase_d     = phase_q;
		tick_d      = tick_q;
		vlq_value_d = vlq_value_q;
		vlq_bytes_d = vlq_bytes_q;
		running_d   = running_q;
		current_d   = current_q;
		held_d      = held_q;
		meta_kind_d = meta_kind_q;
		skip_d      = skip_q;
		tempo_d     = tempo_q;
		res_valid   = 1'b0;
		res         = '0;
		res.tick    = tick_q;

		unique case (phase_q)
			mtep_pkg::PH_STATUS: begin
				if (!b[7]) begin
					// Data byte: reuse running status if there is one.
					if (running_q == 8'd0) begin
						phase_d = mtep_pkg::PH_DELTA;
					end else begin
						current_d = running_q;
						if (two_data(run_type)) begin
							held_d  = b;
							phase_d = mtep_pkg::PH_DATA2;
						end else begin
							phase_d = mtep_pkg::PH_DELTA;
						end
					end
				end else begin
					if (b < mtep_pkg::ST_SYSEX) begin
						running_d = b;
					end
					current_d = b;
					if (b == mtep_pkg::ST_META) begin
						phase_d = mtep_pkg::PH_META_TYPE;
					end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ESC) begin
						vlq_value_d = '0;
						vlq_bytes_d = '0;
						phase_d     = mtep_pkg::PH_SYSEX_LEN;
					end else if (two_data(b_type)) begin
						phase_d = mtep_pkg::PH_DATA1;
					end else if (b_type == mtep_pkg::ST_PROGRAM ||
						b_type == mtep_pkg::ST_CHAN_PRESS) begin
						phase_d = mtep_pkg::PH_SKIP1;
					end else begin
						phase_d = mtep_pkg::PH_DELTA;
					end
				end
			end
			mtep_pkg::PH_DATA1: begin
				held_d  = b;
				phase_d = mtep_pkg::PH_DATA2;
			end
			mtep_pkg::PH_DATA2: begin
				// Only note off, note on and control change are reported.
				if (cur_type == mtep_pkg::ST_NOTE_OFF || cur_type == mtep_pkg::ST_NOTE_ON ||
					cur_type == mtep_pkg::ST_CTRL) begin
					res_valid       = 1'b1;
					res.event_kind  = mtep_pkg::KIND_CHANNEL;
					res.status_byte = current_q;
					res.first_data  = held_q;
					res.second_data = b;
				end
				phase_d = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_SKIP1: begin
				phase_d = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_META_TYPE: begin
				meta_kind_d = b;
				vlq_value_d = '0;
				vlq_bytes_d = '0;
				phase_d     = mtep_pkg::PH_META_LEN;
			end
			mtep_pkg::PH_META_LEN: begin
				vlq_value_d = vlq_next;
				vlq_bytes_d = vlq_cnt_next;
				if (vlq_done) begin
					vlq_value_d = '0;
					vlq_bytes_d = '0;
					if (meta_kind_q == mtep_pkg::META_TEMPO && vlq_next == mtep_pkg::TEMPO_LEN) begin
						tempo_d = '0;
						skip_d  = mtep_pkg::TEMPO_LEN;
						phase_d = mtep_pkg::PH_TEMPO;
					end else if (meta_kind_q == mtep_pkg::META_EOT) begin
						res_valid       = 1'b1;
						res.event_kind  = mtep_pkg::KIND_EOT;
						res.status_byte = mtep_pkg::ST_META;
						res.first_data  = mtep_pkg::META_EOT;
						phase_d         = mtep_pkg::PH_DONE;
					end else begin
						skip_d  = vlq_next;
						phase_d = (vlq_next == 28'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
					end
				end
			end
			mtep_pkg::PH_TEMPO: begin
				tempo_d = tempo_next;
				skip_d  = skip_dec;
				if (skip_dec == 28'd0) begin
					res_valid       = 1'b1;
					res.event_kind  = mtep_pkg::KIND_TEMPO;
					res.status_byte = mtep_pkg::ST_META;
					res.first_data  = mtep_pkg::META_TEMPO;
					res.tempo_us    = tempo_next;
					phase_d         = mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_SYSEX_LEN: begin
				vlq_value_d = vlq_next;
				vlq_bytes_d = vlq_cnt_next;
				if (vlq_done) begin
					vlq_value_d = '0;
					vlq_bytes_d = '0;
					skip_d      = vlq_next;
					phase_d     = (vlq_next == 28'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
				end
			end
			mtep_pkg::PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 28'd0) begin
					phase_d = mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_DONE: begin
				phase_d = mtep_pkg::PH_DONE;
			end
			default: begin
				// Delta time; unused phase codes behave the same way.
				vlq_value_d = vlq_next;
				vlq_bytes_d = vlq_cnt_next;
				if (vlq_done) begin
					tick_d      = tick_q + {4'd0, vlq_next};
					vlq_value_d = '0;
					vlq_bytes_d = '0;
					phase_d     = mtep_pkg::PH_STATUS;
				end else begin
					phase_d = mtep_pkg::PH_DELTA;
				end
			end
		endcase

		// The final byte of the track returns everything to reset.
		if (item.last_of_track) begin
			phase_d     = mtep_pkg::PH_DELTA;
			tick_d      = '0;
			vlq_value_d = '0;
			vlq_bytes_d = '0;
			running_d   = '0;
			current_d   = '0;
			held_d      = '0;
			meta_kind_d = '0;
			skip_d      = '0;
			tempo_d     = '0;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mtep_pkg::PH_DELTA;
			tick_q      <= '0;
			vlq_value_q <= '0;
			vlq_bytes_q <= '0;
			running_q   <= '0;
			current_q   <= '0;
			held_q      <= '0;
			meta_kind_q <= '0;
			skip_q      <= '0;
			tempo_q     <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			tick_q      <= tick_d;
			vlq_value_q <= vlq_value_d;
			vlq_bytes_q <= vlq_bytes_d;
			running_q   <= running_d;
			current_q   <= current_d;
			held_q      <= held_d;
			meta_kind_q <= meta_kind_d;
			skip_q      <= skip_d;
			tempo_q     <= tempo_d;
		end
	end

endmodule

`default_nettype wire

/* src/midi_track_event_parser.sv */
// Path: a byte accepted into the input register is parsed there, and its event,
// if any, is then registered into the result register and offered on result.
// Throughput: one byte per cycle; the input register and the result register
// both advance whenever the result register is empty or is being taken.
// Reset: arst_n clears all parser state to the delta-time phase with tick zero.
`default_nettype none

module midi_track_event_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_ready,
	input  mtep_pkg::in_item_t   item,
	output logic                 result_valid,
	input  wire                  result_ready,
	output mtep_pkg::out_item_t  result
);

	logic                valid_s1;
	mtep_pkg::in_item_t  item_s1;
	logic                advance;
	logic                res_valid;
	mtep_pkg::out_item_t res;

	// The parsed byte needs a free result slot to move on.
	assign advance    = !result_valid || result_ready;
	assign item_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	mtep_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (valid_s1 && advance),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// Result register; a new event replaces one that is being transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			result <= res;
		end
	end

endmodule

`default_nettype wire
